// ----- rtl/assert_macros.svh -----
// assertion macros used by the rtl top, sorted_priority_queue_top
// no dependencies; compiled out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// checked while out of reset
`define SPQ_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// checked on every rising edge, reset included
`define SPQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SPQ_ASSERT(lbl, clk, rstn, prop, msg)
`define SPQ_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ----- rtl/spq_pkg.sv -----
// types and constants for the sorted priority queue
// no dependencies
package spq_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int DATA_W       = 32;
    localparam int OCC_W        = 5;

    typedef enum logic [1:0] {
        ACT_ENQUEUE = 2'd0,
        ACT_DEQUEUE = 2'd1,
        ACT_CLEAR   = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // broadcast to every cell of the row
    typedef struct packed {
        logic                     insert;
        logic                     pop;
        logic signed [DATA_W-1:0] value;
    } t_cell_ctrl;

endpackage

// ----- rtl/spq_cell.sv -----
// one storage cell of the sorted row: holds a value, compares it with the
// broadcast value and shifts toward either neighbor; uses spq_pkg
module spq_cell (
    input  logic                             i_clk,
    input  spq_pkg::t_cell_ctrl              i_ctrl,
    input  logic                             i_occupied,
    input  logic                             i_left_gt,
    input  logic signed [spq_pkg::DATA_W-1:0] i_left_val,
    input  logic signed [spq_pkg::DATA_W-1:0] i_right_val,
    output logic                             o_gt,
    output logic signed [spq_pkg::DATA_W-1:0] o_val
);
    import spq_pkg::*;

    logic signed [DATA_W-1:0] r_val;
    logic signed [DATA_W-1:0] n_val;

    // stored entry strictly larger than the incoming one stays in place
    assign o_gt  = i_occupied && (r_val > i_ctrl.value);
    assign o_val = r_val;

    always_comb begin
        n_val = r_val;
        if (i_ctrl.insert) begin
            if (!o_gt) begin
                n_val = i_left_gt ? i_ctrl.value : i_left_val;
            end
        end else if (i_ctrl.pop) begin
            n_val = i_right_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

// ----- rtl/sorted_priority_queue_top.sv -----
// sorted max-priority queue: the result is registered, valid in the cycle after its item
// is accepted; one item per cycle unless the output stalls; every cell compares against
// the new value and shifts in the same cycle, so the single compare-and-shift step sets the rate
// reset (synchronous, active low) empties the queue and drops any pending
// result; stored values are undefined until written
// uses spq_pkg, spq_cell and assert_macros.svh
`include "assert_macros.svh"

module sorted_priority_queue_top #(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // value[31:0]
    input  logic [1:0]  s_axis_tuser,   // action[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // top_value[31:0], occupancy[36:32], is_empty[37]
    output logic [1:0]  m_axis_tuser    // status[1:0]
);
    import spq_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    logic [CW-1:0]            r_count;
    logic [CW-1:0]            n_count;
    logic                     r_m_valid;
    t_status                  r_status;
    t_status                  n_status;
    logic signed [DATA_W-1:0] r_top;
    logic signed [DATA_W-1:0] n_top;
    logic [OCC_W-1:0]         r_occ;
    logic                     r_empty;

    logic                     in_acc;
    logic                     pop_acc;
    t_action                  act;
    t_cell_ctrl               ctrl;
    logic                     is_full;
    logic                     is_empty_now;

    logic                     gt   [CAPACITY];
    logic signed [DATA_W-1:0] vals [CAPACITY];

    assign s_axis_tready = !r_m_valid || m_axis_tready;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign act           = t_action'(s_axis_tuser);
    assign is_full       = (r_count == CAP_C);
    assign is_empty_now  = (r_count == '0);
    assign pop_acc       = in_acc && (act == ACT_DEQUEUE) && !is_empty_now;

    always_comb begin
        n_count     = r_count;
        n_status    = ST_OK;
        n_top       = '0;
        ctrl.insert = 1'b0;
        ctrl.pop    = 1'b0;
        ctrl.value  = $signed(s_axis_tdata);
        unique case (act)
            ACT_ENQUEUE: begin
                if (is_full) begin
                    n_status = ST_FULL;
                end else begin
                    ctrl.insert = in_acc;
                    n_count     = r_count + CW'(1);
                end
            end
            ACT_DEQUEUE: begin
                if (is_empty_now) begin
                    n_status = ST_EMPTY;
                end else begin
                    ctrl.pop = in_acc;
                    n_top    = vals[0];
                    n_count  = r_count - CW'(1);
                end
            end
            ACT_CLEAR: begin
                n_count = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++) begin : g_cell
            localparam logic [CW-1:0] IDX = CW'(i);
            logic                     left_gt;
            logic signed [DATA_W-1:0] left_val;
            logic signed [DATA_W-1:0] right_val;

            if (i == 0) begin : g_head
                assign left_gt  = 1'b1;
                assign left_val = ctrl.value;
            end else begin : g_body
                assign left_gt  = gt[i-1];
                assign left_val = vals[i-1];
            end

            if (i == CAPACITY - 1) begin : g_tail
                assign right_val = vals[i];
            end else begin : g_inner
                assign right_val = vals[i+1];
            end

            spq_cell u_cell (
                .i_clk       (i_clk),
                .i_ctrl      (ctrl),
                .i_occupied  (IDX < r_count),
                .i_left_gt   (left_gt),
                .i_left_val  (left_val),
                .i_right_val (right_val),
                .o_gt        (gt[i]),
                .o_val       (vals[i])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_count   <= n_count;
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_status <= n_status;
            r_top    <= n_top;
            r_occ    <= OCC_W'(n_count);
            r_empty  <= (n_count == '0);
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {2'b00, r_empty, r_occ, r_top};
    assign m_axis_tuser  = r_status;

    `SPQ_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CAP_C, "count above capacity")
    `SPQ_ASSERT(a_pop_head, i_clk, i_rst_n, pop_acc |=> r_top == $past(vals[0]), "wrong head")
    `SPQ_ASSERT(a_sorted, i_clk, i_rst_n, r_count >= CW'(2) |-> vals[0] >= vals[1], "unsorted")
    `SPQ_ASSERT_ALWAYS(a_reset, i_clk, !i_rst_n |=> r_count == '0 && !r_m_valid, "not reset")

endmodule

// ----- bench/tb.sv -----
// self-checking bench for sorted_priority_queue_top: directed table, then random items
// carries its own model of the sorted store; depends on spq_pkg and the rtl top
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import spq_pkg::*;

    localparam int           QCAP         = CAPACITY_DEF;
    localparam logic [1:0]   ACT_UNUSED   = 2'd3;
    localparam int           RAND_PER_PH  = 375;
    localparam int           HOLD_CYCLES  = 80;
    localparam int           STUCK_LIMIT  = 3000;

    typedef struct {
        t_status            st;
        logic signed [31:0] top;
        logic [4:0]         occ;
        logic               empty;
    } t_res;

    typedef struct {
        logic [1:0]  act;
        logic [31:0] value;
        bit          typed;
        t_res        want;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;     // value[31:0]
    logic [1:0]  s_axis_tuser = '0;     // action[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;          // top_value[31:0], occupancy[36:32], is_empty[37]
    logic [1:0]  m_axis_tuser;          // status[1:0]

    sorted_priority_queue_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // model state: largest value at index 0
    logic signed [31:0] pq_store [QCAP];
    int unsigned        pq_count = 0;

    t_res      pending_q[$];
    t_stim_row dir_rows[$];
    int        err_count = 0;
    int        stall_phase = 0;
    int        tx_idle_pct = 17;
    int        rx_idle_pct = 82;
    bit        hold_done = 1'b0;

    function automatic t_res pq_predict(input logic [1:0] act, input logic signed [31:0] v);
        int   pos;
        int   i;
        t_res r;
        r.st  = ST_OK;
        r.top = '0;
        if (act == ACT_ENQUEUE) begin
            if (pq_count >= QCAP) begin
                r.st = ST_FULL;
            end else begin
                pos = 0;
                while (pos < pq_count && pq_store[pos] > v) pos++;
                for (i = pq_count; i > pos; i--) pq_store[i] = pq_store[i-1];
                pq_store[pos] = v;
                pq_count++;
            end
        end else if (act == ACT_DEQUEUE) begin
            if (pq_count == 0) begin
                r.st = ST_EMPTY;
            end else begin
                r.top = pq_store[0];
                for (i = 1; i < pq_count; i++) pq_store[i-1] = pq_store[i];
                pq_count--;
            end
        end else if (act == ACT_CLEAR) begin
            pq_count = 0;
        end
        r.occ   = pq_count[4:0];
        r.empty = (pq_count == 0);
        return r;
    endfunction

    function automatic t_stim_row mk_row(input logic [1:0] act, input logic [31:0] val,
                                         input bit typed, input t_status st,
                                         input logic [31:0] top, input logic [4:0] occ,
                                         input logic empty);
        t_stim_row row;
        row.act        = act;
        row.value      = val;
        row.typed      = typed;
        row.want.st    = st;
        row.want.top   = top;
        row.want.occ   = occ;
        row.want.empty = empty;
        return row;
    endfunction

    task automatic report_mismatch(input string what, input logic [39:0] got,
                                   input logic [39:0] want);
        $display("mismatch %s at %0t: got %h want %h", what, $realtime, got, want);
        err_count++;
    endtask

    // offer one item, wait for it to be taken, queue what it should produce
    task automatic send_item(input logic [1:0] act, input logic [31:0] val,
                             input bit typed, input t_res typed_res);
        t_res r;
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = val;
        s_axis_tuser  = act;
        do @(posedge i_clk); while (!s_axis_tready);
        r = pq_predict(act, val);
        if (typed)
            pending_q.push_back(typed_res);
        else
            pending_q.push_back(r);
    endtask

    // receiver: random backpressure, one long hold at the start of the no-idle phase
    initial begin
        forever begin
            @(negedge i_clk);
            if (stall_phase == 2 && !hold_done) begin
                m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_done = 1'b1;
            end
            m_axis_tready = ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_res e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_q.size() == 0) begin
                report_mismatch("unexpected item", m_axis_tdata, '0);
            end else begin
                e = pending_q.pop_front();
                if (m_axis_tuser !== e.st)
                    report_mismatch("status", 40'(m_axis_tuser), 40'(e.st));
                if (m_axis_tdata[31:0] !== e.top)
                    report_mismatch("top_value", 40'(m_axis_tdata[31:0]), 40'(e.top));
                if (m_axis_tdata[36:32] !== e.occ)
                    report_mismatch("occupancy", 40'(m_axis_tdata[36:32]), 40'(e.occ));
                if (m_axis_tdata[37] !== e.empty)
                    report_mismatch("is_empty", 40'(m_axis_tdata[37]), 40'(e.empty));
                if (m_axis_tdata[39:38] !== 2'b00)
                    report_mismatch("padding", 40'(m_axis_tdata[39:38]), '0);
            end
        end
    end

    // watchdog on cycles without any item moving
    int stuck_cycles = 0;
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    initial begin
        logic [1:0]  act;
        logic [31:0] val;
        int          enq_bias;
        int          r;
        t_res        none;

        none = '{ST_OK, '0, '0, 1'b0};

        dir_rows.push_back(mk_row(ACT_DEQUEUE, 32'h0,        1, ST_EMPTY, 32'h0, 5'd0, 1'b1));
        dir_rows.push_back(mk_row(ACT_CLEAR,   32'h0,        1, ST_OK,    32'h0, 5'd0, 1'b1));
        dir_rows.push_back(mk_row(ACT_UNUSED,  32'hFFFFFFFF, 1, ST_OK,    32'h0, 5'd0, 1'b1));
        dir_rows.push_back(mk_row(ACT_ENQUEUE, 32'h7FFFFFFF, 1, ST_OK,    32'h0, 5'd1, 1'b0));
        dir_rows.push_back(mk_row(ACT_ENQUEUE, 32'h80000000, 1, ST_OK,    32'h0, 5'd2, 1'b0));
        dir_rows.push_back(mk_row(ACT_ENQUEUE, 32'h0,        0, ST_OK,    32'h0, 5'd0, 1'b0));
        // equal value goes ahead of its twin
        dir_rows.push_back(mk_row(ACT_ENQUEUE, 32'h0,        0, ST_OK,    32'h0, 5'd0, 1'b0));
        dir_rows.push_back(mk_row(ACT_ENQUEUE, 32'hFFFFFFFF, 0, ST_OK,    32'h0, 5'd0, 1'b0));
        dir_rows.push_back(mk_row(ACT_DEQUEUE, 32'h0,        1, ST_OK, 32'h7FFFFFFF, 5'd4, 1'b0));
        dir_rows.push_back(mk_row(ACT_UNUSED,  32'h12345678, 1, ST_OK,    32'h0, 5'd4, 1'b0));
        dir_rows.push_back(mk_row(ACT_ENQUEUE, 32'h7FFFFFFF, 0, ST_OK, 32'h0, 5'd0, 1'b0));
        dir_rows.push_back(mk_row(ACT_ENQUEUE, 32'd100,      0, ST_OK, 32'h0, 5'd0, 1'b0));
        dir_rows.push_back(mk_row(ACT_ENQUEUE, -32'sd100,    0, ST_OK, 32'h0, 5'd0, 1'b0));
        dir_rows.push_back(mk_row(ACT_ENQUEUE, 32'h40000000, 0, ST_OK, 32'h0, 5'd0, 1'b0));
        dir_rows.push_back(mk_row(ACT_ENQUEUE, 32'hC0000000, 0, ST_OK, 32'h0, 5'd0, 1'b0));
        dir_rows.push_back(mk_row(ACT_ENQUEUE, 32'd7,        0, ST_OK, 32'h0, 5'd0, 1'b0));
        dir_rows.push_back(mk_row(ACT_ENQUEUE, 32'd7,        0, ST_OK, 32'h0, 5'd0, 1'b0));
        dir_rows.push_back(mk_row(ACT_ENQUEUE, -32'sd7,      0, ST_OK, 32'h0, 5'd0, 1'b0));
        dir_rows.push_back(mk_row(ACT_ENQUEUE, 32'h80000000, 0, ST_OK, 32'h0, 5'd0, 1'b0));
        dir_rows.push_back(mk_row(ACT_ENQUEUE, 32'd1,        0, ST_OK, 32'h0, 5'd0, 1'b0));
        dir_rows.push_back(mk_row(ACT_ENQUEUE, 32'd2,        0, ST_OK, 32'h0, 5'd0, 1'b0));
        dir_rows.push_back(mk_row(ACT_ENQUEUE, 32'd3,        0, ST_OK, 32'h0, 5'd0, 1'b0));
        // store is full now
        dir_rows.push_back(mk_row(ACT_ENQUEUE, 32'd5,        1, ST_FULL,  32'h0, 5'd16, 1'b0));
        dir_rows.push_back(mk_row(ACT_DEQUEUE, 32'h0,        0, ST_OK,    32'h0, 5'd0,  1'b0));
        dir_rows.push_back(mk_row(ACT_CLEAR,   32'hA5A5A5A5, 1, ST_OK,    32'h0, 5'd0,  1'b1));
        dir_rows.push_back(mk_row(ACT_DEQUEUE, 32'h0,        1, ST_EMPTY, 32'h0, 5'd0,  1'b1));

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[n])
            send_item(dir_rows[n].act, dir_rows[n].value, dir_rows[n].typed, dir_rows[n].want);

        for (int ph = 0; ph < 3; ph++) begin
            stall_phase = ph;
            tx_idle_pct = (ph == 0) ? 17 : (ph == 1) ? 82 : 0;
            rx_idle_pct = (ph == 0) ? 82 : (ph == 1) ? 17 : 0;
            enq_bias = 75;
            for (int n = 0; n < RAND_PER_PH; n++) begin
                // swing between filling and draining so full and empty both come up
                if (n % 40 == 0) enq_bias = (enq_bias == 75) ? 25 : 75;
                r = $urandom_range(99);
                if (r < 2)
                    act = ACT_UNUSED;
                else if (r < 5)
                    act = ACT_CLEAR;
                else if ($urandom_range(99) < enq_bias)
                    act = ACT_ENQUEUE;
                else
                    act = ACT_DEQUEUE;
                case ($urandom_range(9))
                    0:       val = 32'h7FFFFFFF;
                    1:       val = 32'h80000000;
                    2, 3, 4: val = int'($urandom_range(15)) - 8;   // many equal values
                    default: val = $urandom();
                endcase
                send_item(act, val, 1'b0, none);
            end
        end

        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (pending_q.size() != 0)
            report_mismatch("missing items", 40'(pending_q.size()), '0);

        if (err_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
